[rtl/core/olir_pkg.sv]
// Shared types and constants for the ordered list block.
`timescale 1ns / 1ps

package olir_pkg;

    localparam int WORD_W  = 32;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_GET    = 2'd2,
        MODE_REMOVE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_mode                      mode;
        logic [INDEX_W-1:0]         index;
        logic signed [WORD_W-1:0]   value;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0]   read_value;
        logic [COUNT_W-1:0]         count;
        t_status                    status;
    } t_rsp;

    // broadcast to every cell of the row
    typedef struct packed {
        logic wr_en;    // load the request word at the write position
        logic up_en;    // open a gap: take the lower neighbor's word
        logic dn_en;    // close a gap: take the upper neighbor's word
    } t_cell_ctl;

endpackage

[rtl/core/olir_cell.sv]
// One list position: holds a word and moves it to or from its neighbors.
`timescale 1ns / 1ps

module olir_cell import olir_pkg::*; #(
    parameter int PW = 5
) (
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic [PW-1:0]            i_pos,
    input  logic [PW-1:0]            i_wr_pos,
    input  logic [PW-1:0]            i_idx,
    input  logic [PW-1:0]            i_count,
    input  logic signed [WORD_W-1:0] i_value,
    input  logic signed [WORD_W-1:0] i_left,
    input  logic signed [WORD_W-1:0] i_right,
    output logic signed [WORD_W-1:0] o_data
);

    logic signed [WORD_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && (i_pos == i_wr_pos)) begin
            r_data <= i_value;
        end else if (i_ctl.up_en && (i_pos > i_wr_pos) && (i_pos <= i_count)) begin
            r_data <= i_left;
        end else if (i_ctl.dn_en && (i_pos >= i_idx) && ((i_pos + PW'(1)) < i_count)) begin
            r_data <= i_right;
        end
    end

    assign o_data = r_data;

endmodule

[rtl/core/ordered_list_insert_remove.sv]
// Top level of the fixed-capacity ordered list built as a row of cells.
`timescale 1ns / 1ps
//
//  channel   | valid        | stall        | payload
//  ----------+--------------+--------------+------------------------------
//  request   | i_req_valid  | o_req_stall  | i_req (mode, index, value)
//  response  | o_rsp_valid  | i_rsp_stall  | o_rsp (read_value, count, status)
//
//  One request per cycle unless stalled: every cell of the row loads,
//  shifts or holds in the same edge that takes the request, and that
//  edge also loads the response register. The row's parallel shift sets this.
//  Reset clears the count and the response valid; entry words are not
//  cleared, only positions below the count are ever read.
//  The request side stalls only while a response waits on a stalled
//  output; a request is taken in the same cycle the old response leaves.

module ordered_list_insert_remove import olir_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    // count width holds 0..CAPACITY; positions compare at the wider of count and index
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PW  = (CW > INDEX_W) ? CW : INDEX_W;
    // cells reachable by a get index
    localparam int NRD = (CAPACITY < (1 << INDEX_W)) ? CAPACITY : (1 << INDEX_W);

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_rsp_valid;
    t_rsp                     r_rsp;

    logic                     w_accept;
    logic                     w_full;
    logic [PW-1:0]            w_idx;
    logic [PW-1:0]            w_cnt;
    logic [PW-1:0]            w_wr_pos;
    t_cell_ctl                w_ctl;
    t_status                  w_status;
    logic                     w_get_hit;
    logic signed [WORD_W-1:0] w_rd;
    logic signed [WORD_W-1:0] w_data [CAPACITY];

    assign o_req_stall = r_rsp_valid & i_rsp_stall;
    assign w_accept    = i_req_valid & ~o_req_stall;

    assign w_full = (r_count == CW'(CAPACITY));
    assign w_idx  = PW'(i_req.index);
    assign w_cnt  = PW'(r_count);

    // decode the request into row controls, next count and status
    always_comb begin
        w_ctl     = '0;
        w_wr_pos  = w_cnt;
        n_count   = r_count;
        w_status  = ST_OK;
        w_get_hit = 1'b0;
        case (i_req.mode)
            MODE_APPEND: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.wr_en = 1'b1;
                    w_wr_pos    = w_cnt;
                    n_count     = r_count + CW'(1);
                end
            end
            MODE_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (r_count == '0) begin
                    // empty list: lands at the head whatever the index
                    w_ctl.wr_en = 1'b1;
                    w_wr_pos    = '0;
                    n_count     = CW'(1);
                end else if (w_idx > w_cnt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctl.wr_en = 1'b1;
                    w_ctl.up_en = 1'b1;
                    w_wr_pos    = w_idx;
                    n_count     = r_count + CW'(1);
                end
            end
            MODE_GET: begin
                if (w_idx >= w_cnt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_get_hit = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (w_idx >= w_cnt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctl.dn_en = 1'b1;
                    n_count     = r_count - CW'(1);
                end
            end
            default: begin
                w_status = ST_RANGE;
            end
        endcase
        if (!w_accept) begin
            w_ctl = '0;
        end
    end

    // the row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [WORD_W-1:0] w_left;
        logic signed [WORD_W-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = i_req.value;
        end else begin : g_body_l
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body_r
            assign w_right = w_data[g+1];
        end

        olir_cell #(
            .PW(PW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_pos    (PW'(g)),
            .i_wr_pos (w_wr_pos),
            .i_idx    (w_idx),
            .i_count  (w_cnt),
            .i_value  (i_req.value),
            .i_left   (w_left),
            .i_right  (w_right),
            .o_data   (w_data[g])
        );
    end

    // read select over the cells a 4-bit index can reach
    always_comb begin
        w_rd = '0;
        for (int j = 0; j < NRD; j++) begin
            if (w_get_hit && (w_idx == PW'(j))) begin
                w_rd = w_rd | w_data[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // response payload; count reported modulo 32
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp.read_value <= w_rd;
            r_rsp.count      <= COUNT_W'(n_count);
            r_rsp.status     <= w_status;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

[rtl/core/olir_checker.sv]
// Port-level checks for the ordered list block, bound to the top level.
`timescale 1ns / 1ps

module olir_checker import olir_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_stall,
    input t_req i_req,
    input logic o_rsp_valid,
    input logic i_rsp_stall,
    input t_rsp o_rsp
);

    // a stalled response stays up
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_stall) |=> o_rsp_valid)
        else $error("response dropped while stalled");

    // each taken request answers in the next cycle
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) |=> o_rsp_valid)
        else $error("no response one cycle after request");

    // full is only reported at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_rsp.status == ST_FULL)) |-> (o_rsp.count == COUNT_W'(CAPACITY)))
        else $error("full status below capacity");

    // read data is zero on any error
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_rsp.status != ST_OK)) |-> (o_rsp.read_value == '0))
        else $error("nonzero read data on error");

endmodule

bind ordered_list_insert_remove olir_checker #(.CAPACITY(CAPACITY)) u_olir_checker (.*);

[tb/sv/ordered_list_insert_remove_checker.sv]
// Response checker for the ordered list: mirrors the list and compares every response.
`timescale 1ns / 1ps

module ordered_list_insert_remove_checker import olir_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_stall,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_stall,
    input  t_rsp i_rsp,
    output int   o_errors,
    output int   o_pending,
    output int   o_requests,
    output int   o_full_hits,
    output int   o_range_hits,
    output int   o_peak_len
);

    typedef struct packed {
        t_req req;
        t_rsp rsp;
    } t_answer;

    logic signed [WORD_W-1:0] list_words [CAPACITY];
    int      list_len;
    t_answer answers_due [$];

    int fail_total;
    int req_total;
    int full_total;
    int range_total;
    int peak_total;
    int due_total;

    assign o_errors     = fail_total;
    assign o_pending    = due_total;
    assign o_requests   = req_total;
    assign o_full_hits  = full_total;
    assign o_range_hits = range_total;
    assign o_peak_len   = peak_total;

    // Apply one request to the mirrored list and work out its response.
    task automatic apply_list_op(input t_req r, output t_rsp p);
        int                       idx;
        int                       k;
        logic signed [WORD_W-1:0] rd;
        t_status                  st;
        idx = int'(r.index);
        rd  = '0;
        st  = ST_OK;
        case (r.mode)
            MODE_APPEND: begin
                if (list_len >= CAPACITY) begin
                    st = ST_FULL;
                end else begin
                    list_words[list_len] = r.value;
                    list_len++;
                end
            end
            MODE_INSERT: begin
                if (list_len >= CAPACITY) begin
                    st = ST_FULL;
                end else if (list_len == 0) begin
                    // empty list: index is ignored
                    list_words[0] = r.value;
                    list_len = 1;
                end else if (idx > list_len) begin
                    st = ST_RANGE;
                end else begin
                    for (k = list_len; k > idx; k--) list_words[k] = list_words[k-1];
                    list_words[idx] = r.value;
                    list_len++;
                end
            end
            MODE_GET: begin
                if (idx >= list_len) st = ST_RANGE;
                else rd = list_words[idx];
            end
            default: begin
                if (idx >= list_len) begin
                    st = ST_RANGE;
                end else begin
                    list_len--;
                    for (k = idx; k < list_len; k++) list_words[k] = list_words[k+1];
                end
            end
        endcase
        p.read_value = rd;
        p.count      = COUNT_W'(list_len);
        p.status     = st;
    endtask

    always @(posedge i_clk) begin : track
        t_answer due;
        t_rsp    want;
        if (!i_rst_n) begin
            list_len = 0;
            foreach (list_words[k]) list_words[k] = '0;
            answers_due.delete();
            due_total = 0;
        end else begin
            // a response leaving now answers a request taken at an earlier edge
            if (i_rsp_valid && !i_rsp_stall) begin
                if (answers_due.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("[%0t] unexpected response: read_value %0d count %0d",
                                 $realtime, i_rsp.read_value, i_rsp.count,
                                 " status %0d", i_rsp.status);
                end else begin
                    due = answers_due.pop_front();
                    if (i_rsp.read_value !== due.rsp.read_value ||
                        i_rsp.count !== due.rsp.count ||
                        i_rsp.status !== due.rsp.status) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("[%0t] mismatch on %s index %0d value %0d", $realtime,
                                     due.req.mode.name(), due.req.index, due.req.value);
                            $display("    expected read_value %0d count %0d status %0d",
                                     due.rsp.read_value, due.rsp.count, due.rsp.status);
                            $display("    actual   read_value %0d count %0d status %0d",
                                     i_rsp.read_value, i_rsp.count, i_rsp.status);
                        end
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                apply_list_op(i_req, want);
                answers_due.push_back({i_req, want});
                req_total++;
                if (want.status == ST_FULL) full_total++;
                if (want.status == ST_RANGE) range_total++;
                if (list_len > peak_total) peak_total = list_len;
            end
            due_total = answers_due.size();
        end
    end

endmodule

[tb/sv/ordered_list_insert_remove_tb.sv]
// Testbench top for the ordered list: request stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module ordered_list_insert_remove_tb import olir_pkg::*;;

    localparam int CAPACITY    = 16;
    localparam int PHASE_ITEMS = 500;      // minimum random requests per idling mix
    localparam int CYCLE_LIMIT = 200_000;  // several times the slowest legal run

    // which way a stretch of random requests pushes the list length
    typedef enum int {
        LEAN_GROW,
        LEAN_SHRINK,
        LEAN_MIX
    } t_lean;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    t_req i_req       = '0;
    logic i_rsp_stall = 1'b0;
    logic o_req_stall;
    logic o_rsp_valid;
    t_rsp o_rsp;

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int cycle_cnt     = 0;

    int err_cnt;
    int pending_cnt;
    int req_cnt;
    int full_cnt;
    int range_cnt;
    int peak_len;

    ordered_list_insert_remove #(
        .CAPACITY (CAPACITY)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    ordered_list_insert_remove_checker #(
        .CAPACITY (CAPACITY)
    ) list_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req_stall  (o_req_stall),
        .i_req        (i_req),
        .i_rsp_valid  (o_rsp_valid),
        .i_rsp_stall  (i_rsp_stall),
        .i_rsp        (o_rsp),
        .o_errors     (err_cnt),
        .o_pending    (pending_cnt),
        .o_requests   (req_cnt),
        .o_full_hits  (full_cnt),
        .o_range_hits (range_cnt),
        .o_peak_len   (peak_len)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver side: random stall, never during reset.
    always @(posedge i_clk) begin
        i_rsp_stall <= i_rst_n && ($urandom_range(0, 99) < rsp_stall_pct);
    end

    // Hard stop if the run hangs.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_req make_req(input t_mode mode, input logic [INDEX_W-1:0] index,
                                      input logic signed [WORD_W-1:0] value);
        t_req r;
        r.mode  = mode;
        r.index = index;
        r.value = value;
        return r;
    endfunction

    // Random request; the lean sets the mix of operations so the list
    // swings between empty and full over the run.
    function automatic t_req pick_request(input t_lean lean);
        t_req r;
        int   roll;
        roll = $urandom_range(0, 99);
        case (lean)
            LEAN_GROW:   r.mode = t_mode'(roll < 45 ? MODE_APPEND :
                                          roll < 80 ? MODE_INSERT :
                                          roll < 92 ? MODE_GET : MODE_REMOVE);
            LEAN_SHRINK: r.mode = t_mode'(roll < 8  ? MODE_APPEND :
                                          roll < 16 ? MODE_INSERT :
                                          roll < 36 ? MODE_GET : MODE_REMOVE);
            default:     r.mode = t_mode'(roll < 25 ? MODE_APPEND :
                                          roll < 50 ? MODE_INSERT :
                                          roll < 75 ? MODE_GET : MODE_REMOVE);
        endcase
        // half the indexes lean low, so removes and inserts mostly land
        if ($urandom_range(0, 1) != 0)
            r.index = INDEX_W'($urandom_range(0, 15));
        else
            r.index = INDEX_W'($urandom_range(0, $urandom_range(0, 15)));
        // sprinkle the value extremes among random words
        case ($urandom_range(0, 19))
            0:       r.value = 32'sh7FFF_FFFF;
            1:       r.value = 32'sh8000_0000;
            2:       r.value = '0;
            3:       r.value = -32'sd1;
            default: r.value = $urandom;
        endcase
        return r;
    endfunction

    // Offer one request, with random idle cycles ahead of it, and hold it
    // until the block takes it. Valid is never lowered between back-to-back
    // requests.
    task automatic push_request(input t_req r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
    endtask

    // Hold off new requests until every response is back.
    task automatic wait_all_answered();
        i_req_valid <= 1'b0;
        do @(negedge i_clk); while (pending_cnt != 0);
        @(posedge i_clk);
    endtask

    // One idling mix: stretches of random requests, each with its own lean.
    task automatic run_phase(input int idle_pct, input int stall_pct);
        int    sent;
        int    stretch;
        t_lean lean;
        send_idle_pct = idle_pct;
        rsp_stall_pct <= stall_pct;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            stretch = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
                0:       lean = LEAN_GROW;
                1:       lean = LEAN_SHRINK;
                default: lean = LEAN_MIX;
            endcase
            repeat (stretch) begin
                push_request(pick_request(lean));
                sent++;
            end
        end
        wait_all_answered();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling on either side.
        // empty list: get and remove are both out of range
        push_request(make_req(MODE_GET,    4'd0,  32'sd0));
        push_request(make_req(MODE_REMOVE, 4'd0,  32'sd0));
        // insert into an empty list goes to position 0 whatever the index
        push_request(make_req(MODE_INSERT, 4'd15, 32'sh7FFF_FFFF));
        push_request(make_req(MODE_APPEND, 4'd9,  32'sh8000_0000));
        // index equal to the count appends; past the count is rejected
        push_request(make_req(MODE_INSERT, 4'd2,  -32'sd1));
        push_request(make_req(MODE_INSERT, 4'd5,  32'sd5));
        push_request(make_req(MODE_INSERT, 4'd0,  32'sd0));
        // last entry readable, entry at the count is not
        push_request(make_req(MODE_GET,    4'd3,  32'sh5A5A_5A5A));
        push_request(make_req(MODE_GET,    4'd4,  32'sd0));
        push_request(make_req(MODE_REMOVE, 4'd1,  32'sd0));
        // three held now: fill to capacity, then try to grow past it
        for (int n = 0; n < CAPACITY - 3; n++)
            push_request(make_req(MODE_APPEND, INDEX_W'(n), $urandom));
        push_request(make_req(MODE_APPEND, 4'd0,  32'sd1));
        push_request(make_req(MODE_INSERT, 4'd3,  32'sd2));
        // top slot of a full list, then removes at both ends
        push_request(make_req(MODE_GET,    4'd15, 32'sd0));
        push_request(make_req(MODE_REMOVE, 4'd15, 32'sd0));
        push_request(make_req(MODE_REMOVE, 4'd0,  32'sd0));
        // sender pauses here until the directed responses are all back
        wait_all_answered();

        // Random part over the idling mixes.
        run_phase(0, 0);
        run_phase(45, 0);
        run_phase(0, 45);
        run_phase(21, 21);

        // extra edges at the end catch any stray response
        rsp_stall_pct <= 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);

        $display("Covered %0d requests over four idle/stall mixes;", req_cnt,
                 " list length peaked at %0d of %0d.", peak_len, CAPACITY);
        $display("Rejected as full: %0d; out of range or empty: %0d; mismatches: %0d.",
                 full_cnt, range_cnt, err_cnt);
        if (err_cnt == 0 && pending_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
